// File: sv/lps_pkg.sv
// ============================================================================
// Line pixel stepper package
// Shared sizes, opcodes and the pixel record passed from front to back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

   localparam int COORD_BITS  = 16;
   localparam int MAX_DIM     = 4096;
   localparam int DELTA_BITS  = COORD_BITS + 1;
   localparam int ERR_BITS    = COORD_BITS + 2;
   localparam int CFG_BITS    = 13;
   localparam int INDEX_BITS  = 24;
   localparam int COLOR_BITS  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_BITS = 1;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WIN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIN_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] WIN_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_BITS-1:0] WIN_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
      logic [COLOR_BITS-1:0]        color;
   } pix_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// File: sv/lps_front.sv
// ============================================================================
// Line pixel stepper front end
// Accepts start and step beats, runs the Bresenham recurrence and queues
// each emitted pixel.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lps_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire lps_pkg::op_type                      req_op,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_x_start,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_y_start,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_x_end,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_y_end,
   input  wire logic [lps_pkg::COLOR_BITS-1:0]       req_line_color,
   input  wire lps_pkg::q_status_type                q_status,
   output logic                                      q_push,
   output lps_pkg::pix_type                          q_push_pix
);
   import lps_pkg::*;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] goal_x_ff, goal_x_in;
   logic signed [COORD_BITS-1:0] goal_y_ff, goal_y_in;
   logic [DELTA_BITS-1:0]        delta_x_ff, delta_x_in;
   logic [DELTA_BITS-1:0]        delta_y_ff, delta_y_in;
   logic                         step_x_neg_ff, step_x_neg_in;
   logic                         step_y_neg_ff, step_y_neg_in;
   logic signed [ERR_BITS-1:0]   error_term_ff, error_term_in;
   logic [COLOR_BITS-1:0]        held_color_ff, held_color_in;
   logic                         active_ff, active_in;

   logic                         accept;
   logic                         is_start;
   logic signed [DELTA_BITS-1:0] dx_s, dy_s;
   logic [DELTA_BITS-1:0]        adx, ady;
   logic signed [ERR_BITS:0]     e2;
   logic signed [ERR_BITS:0]     neg_dy;
   logic signed [ERR_BITS:0]     pos_dx;
   logic                         move_x, move_y;
   logic signed [ERR_BITS:0]     err_wide;
   logic signed [COORD_BITS-1:0] inc_x, inc_y;
   logic                         at_goal;

   localparam logic [COORD_BITS-1:0] ONE   = {{(COORD_BITS-1){1'b0}}, 1'b1};
   localparam logic [COORD_BITS-1:0] M_ONE = {COORD_BITS{1'b1}};

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign is_start  = (req_op == OP_START);

   always_comb begin
      dx_s = {req_x_end[COORD_BITS-1], req_x_end} - {req_x_start[COORD_BITS-1], req_x_start};
      dy_s = {req_y_end[COORD_BITS-1], req_y_end} - {req_y_start[COORD_BITS-1], req_y_start};
      adx  = dx_s[DELTA_BITS-1] ? (~dx_s + ONE[0]) : dx_s;
      ady  = dy_s[DELTA_BITS-1] ? (~dy_s + ONE[0]) : dy_s;

      e2     = {error_term_ff, 1'b0};
      neg_dy = -$signed({2'b00, delta_y_ff});
      pos_dx = $signed({2'b00, delta_x_ff});
      move_x = (e2 > neg_dy);
      move_y = (e2 < pos_dx);
      err_wide = {error_term_ff[ERR_BITS-1], error_term_ff}
               - (move_x ? $signed({2'b00, delta_y_ff}) : '0)
               + (move_y ? pos_dx : '0);
      inc_x = step_x_neg_ff ? M_ONE : ONE;
      inc_y = step_y_neg_ff ? M_ONE : ONE;

      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_term_in = error_term_ff;
      held_color_in = held_color_ff;

      if (is_start) begin
         cur_x_in      = req_x_start;
         cur_y_in      = req_y_start;
         goal_x_in     = req_x_end;
         goal_y_in     = req_y_end;
         delta_x_in    = adx;
         delta_y_in    = ady;
         step_x_neg_in = dx_s[DELTA_BITS-1] || (dx_s == '0);
         step_y_neg_in = dy_s[DELTA_BITS-1] || (dy_s == '0);
         error_term_in = $signed({1'b0, adx}) - $signed({1'b0, ady});
         held_color_in = req_line_color;
      end else begin
         if (move_x) begin
            cur_x_in = cur_x_ff + inc_x;
         end
         if (move_y) begin
            cur_y_in = cur_y_ff + inc_y;
         end
         error_term_in = err_wide[ERR_BITS-1:0];
      end

      at_goal   = (cur_x_in == goal_x_in) && (cur_y_in == goal_y_in);
      q_push    = accept && (is_start || active_ff);
      active_in = !at_goal;

      q_push_pix.x     = cur_x_in;
      q_push_pix.y     = cur_y_in;
      q_push_pix.last  = at_goal;
      q_push_pix.color = held_color_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         delta_x_ff    <= '0;
         delta_y_ff    <= '0;
         step_x_neg_ff <= 1'b0;
         step_y_neg_ff <= 1'b0;
         error_term_ff <= '0;
         held_color_ff <= '0;
         active_ff     <= 1'b0;
      end else if (q_push) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         delta_x_ff    <= delta_x_in;
         delta_y_ff    <= delta_y_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         error_term_ff <= error_term_in;
         held_color_ff <= held_color_in;
         active_ff     <= active_in;
      end
   end

   a_no_step_when_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_start && !active_ff) |-> !q_push)
      else $error("A step beat without an active line produced a pixel.");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_push_pix.last) |=> !active_ff)
      else $error("The line stayed active after its end point was emitted.");

endmodule

`default_nettype wire

// File: sv/lps_queue.sv
// ============================================================================
// Line pixel stepper queue
// Short first-in first-out buffer that decouples the stepper from the
// clipping and output stage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lps_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire lps_pkg::pix_type      push_pix,
   input  wire logic                  pop,
   output lps_pkg::pix_type           head_pix,
   output lps_pkg::q_status_type      status
);
   import lps_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);

   pix_type               mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == DEPTH_CNT);
      status.empty = (count_ff == '0);
      head_pix     = mem[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("A pixel was pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("A pixel was popped from an empty queue.");

endmodule

`default_nettype wire

// File: sv/lps_back.sv
// ============================================================================
// Line pixel stepper back end
// Holds the window registers, clips each queued pixel, forms its linear
// index and presents it on the result port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lps_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [lps_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [lps_pkg::CFG_BITS-1:0]         csr_data,
   input  wire lps_pkg::q_status_type                q_status,
   input  wire lps_pkg::pix_type                     q_head_pix,
   output logic                                      q_pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [lps_pkg::COORD_BITS-1:0]     rsp_pix_x,
   output logic signed [lps_pkg::COORD_BITS-1:0]     rsp_pix_y,
   output logic                                      rsp_inside_res,
   output logic [lps_pkg::INDEX_BITS-1:0]            rsp_pix_index,
   output logic [lps_pkg::COLOR_BITS-1:0]            rsp_pix_color,
   output logic                                      rsp_last
);
   import lps_pkg::*;

   localparam int WIDE = 33;
   localparam int DIM_CAP_INT = (MAX_DIM > (2 ** CFG_BITS) - 1) ? (2 ** CFG_BITS) - 1 : MAX_DIM;
   localparam logic [CFG_BITS-1:0] DIM_CAP = CFG_BITS'(DIM_CAP_INT);

   logic [CFG_BITS-1:0]          win_width_ff;
   logic [CFG_BITS-1:0]          win_height_ff;

   logic                         valid_ff;
   logic signed [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic                         inside_ff, inside_in;
   logic [INDEX_BITS-1:0]        index_ff, index_in;
   logic [COLOR_BITS-1:0]        color_ff;
   logic                         last_ff;

   logic [CFG_BITS-1:0]          w_eff, h_eff;
   logic [WIDE-1:0]              x_wide, y_wide;
   logic [2*CFG_BITS-1:0]        prod;
   logic [2*CFG_BITS-1:0]        sum;

   always_comb begin
      w_eff  = (win_width_ff  > DIM_CAP) ? DIM_CAP : win_width_ff;
      h_eff  = (win_height_ff > DIM_CAP) ? DIM_CAP : win_height_ff;
      x_wide = {{(WIDE-COORD_BITS){q_head_pix.x[COORD_BITS-1]}}, q_head_pix.x};
      y_wide = {{(WIDE-COORD_BITS){q_head_pix.y[COORD_BITS-1]}}, q_head_pix.y};
      inside_in = !x_wide[WIDE-1] && (x_wide < {{(WIDE-CFG_BITS){1'b0}}, w_eff})
               && !y_wide[WIDE-1] && (y_wide < {{(WIDE-CFG_BITS){1'b0}}, h_eff});
      prod     = y_wide[CFG_BITS-1:0] * w_eff;
      sum      = prod + {{CFG_BITS{1'b0}}, x_wide[CFG_BITS-1:0]};
      index_in = inside_in ? sum[INDEX_BITS-1:0] : '0;
      q_pop    = !q_status.empty && (!valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_width_ff  <= WIN_WIDTH_RESET;
         win_height_ff <= WIN_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIN_WIDTH:  win_width_ff  <= csr_data;
            CSR_WIN_HEIGHT: win_height_ff <= csr_data;
            default:        win_width_ff  <= win_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pix_x_ff  <= q_head_pix.x;
         pix_y_ff  <= q_head_pix.y;
         inside_ff <= inside_in;
         index_ff  <= index_in;
         color_ff  <= q_head_pix.color;
         last_ff   <= q_head_pix.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pix_x      = pix_x_ff;
   assign rsp_pix_y      = pix_y_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_pix_index  = index_ff;
   assign rsp_pix_color  = color_ff;
   assign rsp_last       = last_ff;

   a_outside_index_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !inside_ff) |-> (index_ff == '0))
      else $error("A pixel outside the window carries a nonzero index.");

endmodule

`default_nettype wire

// File: sv/clipped_line_pixel_stepper.sv
// ============================================================================
// Clipped line pixel stepper
// Bresenham line generator, one pixel per request beat, clipped to a window.
// ============================================================================
// A start beat loads both endpoints and the color and returns the first
// pixel; each step beat returns the next pixel, and a step beat with no line
// in progress returns nothing. The block takes one beat per cycle while req_stall
// is low: the error recurrence in the front stage is combinational, and the clipping
// multiply sits in the output stage behind a four-entry queue, so a pixel
// passes through a queue entry and then the output register. req_stall
// rises only while that queue is full. Window registers are written through
// the csr port, which is always ready, and should change only while idle.
`timescale 1ns / 1ps
`default_nettype none

module clipped_line_pixel_stepper (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire lps_pkg::op_type                      req_op,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_x_start,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_y_start,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_x_end,
   input  wire logic signed [lps_pkg::COORD_BITS-1:0] req_y_end,
   input  wire logic [lps_pkg::COLOR_BITS-1:0]       req_line_color,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [lps_pkg::COORD_BITS-1:0]     rsp_pix_x,
   output logic signed [lps_pkg::COORD_BITS-1:0]     rsp_pix_y,
   output logic                                      rsp_inside_res,
   output logic [lps_pkg::INDEX_BITS-1:0]            rsp_pix_index,
   output logic [lps_pkg::COLOR_BITS-1:0]            rsp_pix_color,
   output logic                                      rsp_last,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lps_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [lps_pkg::CFG_BITS-1:0]         csr_data
);
   import lps_pkg::*;

   q_status_type q_status;
   pix_type      q_push_pix;
   pix_type      q_head_pix;
   logic         q_push;
   logic         q_pop;
   logic         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   lps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_push_pix     (q_push_pix)
   );

   lps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_pix (q_push_pix),
      .pop      (q_pop),
      .head_pix (q_head_pix),
      .status   (q_status)
   );

   lps_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_status       (q_status),
      .q_head_pix     (q_head_pix),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pix_x      (rsp_pix_x),
      .rsp_pix_y      (rsp_pix_y),
      .rsp_inside_res (rsp_inside_res),
      .rsp_pix_index  (rsp_pix_index),
      .rsp_pix_color  (rsp_pix_color),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
